### rtl/lkv_pkg.sv
// Shared types, constants and helpers for the LRU key-value cache.
// No dependencies; used by lkv_cell and lru_key_value_cache.
`default_nettype none

package lkv_pkg;

   localparam int ENTRIES  = 16;
   localparam int KEY_BITS = 16;

   localparam int KEY_PORT_W = 16;
   localparam int VALUE_W    = 32;
   localparam int CAP_W      = 5;
   localparam int FILL_W     = $clog2(ENTRIES + 1);
   localparam int CMP_W      = (FILL_W > CAP_W) ? FILL_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic {
      KIND_GET = 1'b0,
      KIND_PUT = 1'b1
   } kind_type;

   // One stored entry, also what a cell hands to its older neighbor.
   typedef struct packed {
      logic                valid;
      logic [KEY_BITS-1:0] key;
      logic [VALUE_W-1:0]  value;
   } entry_type;

   // Broadcast to every cell for the word in flight.
   typedef struct packed {
      logic                update;  // put, or get that hits
      logic                hit;
      logic                full;    // fill at or above effective capacity
      logic                evict;   // put hit with fill above capacity
      logic [KEY_BITS-1:0] key;
   } cmd_type;

   function automatic logic [KEY_BITS-1:0] key_trunc(input logic [KEY_PORT_W-1:0] k);
      logic [KEY_PORT_W+32-1:0] w;
      begin
         w = {32'b0, k};
         return w[KEY_BITS-1:0];
      end
   endfunction

endpackage

`default_nettype wire

### rtl/lkv_cell.sv
// One position of the recency stack: holds the entry at a fixed rank.
// Depends on lkv_pkg.
`default_nettype none

module lkv_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire lkv_pkg::cmd_type             cmd,
   input  wire lkv_pkg::entry_type           prev,       // from the newer neighbor
   input  wire logic                         next_valid, // older neighbor occupied
   input  wire logic                         found_in,   // match in a newer cell
   input  wire logic [lkv_pkg::VALUE_W-1:0]  acc_in,
   output lkv_pkg::entry_type                ent,
   output logic                              found_out,
   output logic [lkv_pkg::VALUE_W-1:0]       acc_out
);

   logic                         valid_ff, valid_in;
   logic [lkv_pkg::KEY_BITS-1:0] key_ff, key_in;
   logic [lkv_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic                         match;
   logic                         shift;

   assign match     = valid_ff && (key_ff == cmd.key);
   assign found_out = found_in | match;
   assign acc_out   = acc_in | (match ? value_ff : '0);

   assign ent.valid = valid_ff;
   assign ent.key   = key_ff;
   assign ent.value = value_ff;

   // hit: cells up to the matching one move down one rank
   // miss, room left: every occupied rank moves down, first empty cell fills
   // miss, full: oldest entry falls off the end; put hit over capacity: oldest entry is cleared
   always_comb begin
      shift = cmd.update &&
              (cmd.hit ? !found_in : (cmd.full ? valid_ff : prev.valid));
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (shift) begin
         valid_in = prev.valid;
         key_in   = prev.key;
         value_in = prev.value;
      end
      if (cmd.evict && valid_ff && !next_valid) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

### rtl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: request register, chain of cells,
// fill/capacity control and response register. Depends on lkv_pkg, lkv_cell.
//
// Usage:
//   Request: drive req_kind (0 get, 1 put), req_key, req_value and raise
//   start. A word is taken at a rising edge with start high and busy low.
//   busy stays low: a new word may be given every cycle.
//   Response: rsp_strobe is high for exactly one cycle with rsp_hit and
//   rsp_read_value. The receiver cannot stall; every word yields one
//   response, in order.
//   Timing: the word is registered at the accepting edge, runs through the
//   cell chain in the next cycle, and the response is registered at the
//   following edge.
//   Throughput: one word per cycle. A word sees the stack as left by the
//   word before it, since that update lands at the same edge that this
//   word reaches the chain.
//   Config: csr_wr_en/csr_wr_data set the capacity (0 acts as 1, values
//   above the entry count act as the entry count). Write only while idle.
//   Reset (synchronous): all entries empty, fill zero, capacity 16, no
//   response pending. No clearing pass is needed.
//   Structure: one cell per recency rank, rank 0 most recent. The key
//   compare ripples a found flag and the matched value from newest to
//   oldest; on update each shifting cell takes its newer neighbor's entry.
`default_nettype none

module lru_key_value_cache (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_kind,
   input  wire logic [lkv_pkg::KEY_PORT_W-1:0]  req_key,
   input  wire logic [lkv_pkg::VALUE_W-1:0]     req_value,
   output logic                                 rsp_strobe,
   output logic                                 rsp_hit,
   output logic [lkv_pkg::VALUE_W-1:0]          rsp_read_value,
   input  wire logic                            csr_wr_en,
   input  wire logic [lkv_pkg::CAP_W-1:0]       csr_wr_data
);

   localparam int N = lkv_pkg::ENTRIES;

   // request register
   logic                         op_ff;
   lkv_pkg::kind_type            kind_ff;
   logic [lkv_pkg::KEY_BITS-1:0] key_ff;
   logic [lkv_pkg::VALUE_W-1:0]  value_ff;

   // control state
   logic [lkv_pkg::CAP_W-1:0]  cap_ff;
   logic [lkv_pkg::FILL_W-1:0] fill_ff, fill_in;

   // response register
   logic                        strobe_ff;
   logic                        hit_ff;
   logic [lkv_pkg::VALUE_W-1:0] rdata_ff;

   // chain
   lkv_pkg::entry_type          ent_out [N];
   logic                        found   [N+1];
   logic [lkv_pkg::VALUE_W-1:0] acc     [N+1];
   logic [N-1:0]                valid_vec;

   lkv_pkg::cmd_type   cmd;
   lkv_pkg::entry_type new_ent;
   logic [lkv_pkg::CMP_W-1:0] cap_ext, cap_eff, fill_ext;
   logic hit, is_put;

   assign busy = 1'b0;   // one word per cycle, never held off

   assign found[0] = 1'b0;
   assign acc[0]   = '0;
   assign hit      = found[N];
   assign is_put   = (kind_ff == lkv_pkg::KIND_PUT);

   // effective capacity, clamped to 1..ENTRIES
   always_comb begin
      cap_ext  = (lkv_pkg::CMP_W)'(cap_ff);
      fill_ext = (lkv_pkg::CMP_W)'(fill_ff);
      cap_eff  = cap_ext;
      if (cap_ext == '0) begin
         cap_eff = (lkv_pkg::CMP_W)'(1);
      end else if (cap_ext > (lkv_pkg::CMP_W)'(N)) begin
         cap_eff = (lkv_pkg::CMP_W)'(N);
      end
   end

   always_comb begin
      cmd.update = op_ff && (is_put || hit);
      cmd.hit    = hit;
      cmd.full   = (fill_ext >= cap_eff);
      cmd.evict  = op_ff && is_put && hit && (fill_ext > cap_eff);
      cmd.key    = key_ff;

      // entry that enters at rank 0: the touched one, or the new one on put
      new_ent.valid = 1'b1;
      new_ent.key   = key_ff;
      new_ent.value = is_put ? value_ff : acc[N];

      fill_in = fill_ff;
      if (op_ff && is_put) begin
         if (!hit && !cmd.full) begin
            fill_in = fill_ff + (lkv_pkg::FILL_W)'(1);
         end else if (cmd.evict) begin
            fill_in = fill_ff - (lkv_pkg::FILL_W)'(1);
         end
      end
   end

   for (genvar i = 0; i < N; i++) begin : gen_cell
      lkv_pkg::entry_type prev;
      logic               next_valid;

      if (i == 0) begin : g_first
         assign prev = new_ent;
      end else begin : g_rest
         assign prev = ent_out[i-1];
      end

      if (i == N-1) begin : g_last
         assign next_valid = 1'b0;
      end else begin : g_mid
         assign next_valid = ent_out[i+1].valid;
      end

      assign valid_vec[i] = ent_out[i].valid;

      lkv_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev       (prev),
         .next_valid (next_valid),
         .found_in   (found[i]),
         .acc_in     (acc[i]),
         .ent        (ent_out[i]),
         .found_out  (found[i+1]),
         .acc_out    (acc[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff     <= 1'b0;
         cap_ff    <= lkv_pkg::CAP_RESET;
         fill_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         op_ff     <= start && !busy;
         fill_ff   <= fill_in;
         strobe_ff <= op_ff;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         kind_ff  <= lkv_pkg::kind_type'(req_kind);
         key_ff   <= lkv_pkg::key_trunc(req_key);
         value_ff <= req_value;
      end
      hit_ff   <= hit;
      rdata_ff <= (!is_put && hit) ? acc[N] : '0;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_hit        = hit_ff;
   assign rsp_read_value = rdata_ff;

   // occupied ranks form an unbroken run from rank 0, sized by the fill count
   a_valid_contig: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec >> 1) & ~valid_vec) == '0)
      else $error("hole in recency stack");

   a_fill_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(fill_ff))
      else $error("fill count disagrees with occupied cells");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted word produced no response");

   a_data_needs_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_read_value != '0) |-> rsp_hit)
      else $error("read data on a miss");

   a_put_hit_no_grow: assert property (@(posedge clock) disable iff (reset)
      (op_ff && hit) |=> fill_ff <= $past(fill_ff))
      else $error("fill grew on a hit");

endmodule

`default_nettype wire

### test/lru_key_value_cache_test.sv
// Self-checking testbench for lru_key_value_cache: get/put words against an LRU shadow store.
// Depends on lkv_pkg and the lru_key_value_cache RTL; reads no files.
`timescale 1ns / 1ps

module lru_key_value_cache_test;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_WORDS  = 155;
   localparam int POOL_DEPTH   = 24;

   // Shadow copy of the cache. Each accepted word updates it and queues the
   // reply that word must produce; replies are checked oldest first.
   class lru_shadow;
      typedef struct packed {
         logic                        hit;
         logic [lkv_pkg::VALUE_W-1:0] read_value;
      } reply_type;

      logic [lkv_pkg::CAP_W-1:0]    capacity;
      logic [lkv_pkg::KEY_BITS-1:0] keys[lkv_pkg::ENTRIES];
      logic [lkv_pkg::VALUE_W-1:0]  values[lkv_pkg::ENTRIES];
      bit                           valid[lkv_pkg::ENTRIES];
      int unsigned                  rank[lkv_pkg::ENTRIES];   // 0 = most recent
      int unsigned                  fill;
      reply_type                    pending_replies[$];
      int                           errors;

      function new();
         capacity = lkv_pkg::CAP_RESET;
         fill     = 0;
         errors   = 0;
         foreach (valid[i]) begin
            valid[i] = 1'b0;
            rank[i]  = 0;
         end
      endfunction

      // Least recent valid entry, -1 when empty.
      function int oldest_entry();
         int best;
         best = -1;
         for (int i = 0; i < lkv_pkg::ENTRIES; i++)
            if (valid[i] && (best < 0 || rank[i] > rank[best])) best = i;
         return best;
      endfunction

      // Move a valid entry to the front of the recency order.
      function void promote(int idx);
         for (int i = 0; i < lkv_pkg::ENTRIES; i++)
            if (valid[i] && i != idx && rank[i] < rank[idx]) rank[i]++;
         rank[idx] = 0;
      endfunction

      // Place a new most recent entry in a free slot.
      function void insert_newest(int idx, logic [lkv_pkg::KEY_BITS-1:0] k,
                                  logic [lkv_pkg::VALUE_W-1:0] v);
         for (int i = 0; i < lkv_pkg::ENTRIES; i++)
            if (valid[i]) rank[i]++;
         valid[idx]  = 1'b1;
         keys[idx]   = k;
         values[idx] = v;
         rank[idx]   = 0;
      endfunction

      function void note_word(lkv_pkg::kind_type kind, logic [lkv_pkg::KEY_PORT_W-1:0] key,
                              logic [lkv_pkg::VALUE_W-1:0] value);
         int                           idx;
         int                           old;
         int                           slot;
         int unsigned                  cap;
         reply_type                    r;
         logic [lkv_pkg::KEY_BITS-1:0] k;
         k   = key[lkv_pkg::KEY_BITS-1:0];
         cap = capacity;
         if (cap < 1) cap = 1;
         if (cap > lkv_pkg::ENTRIES) cap = lkv_pkg::ENTRIES;
         idx = -1;
         for (int i = 0; i < lkv_pkg::ENTRIES; i++)
            if (idx < 0 && valid[i] && keys[i] == k) idx = i;
         r.hit        = (idx >= 0);
         r.read_value = '0;
         if (kind == lkv_pkg::KIND_GET) begin
            if (idx >= 0) begin
               promote(idx);
               r.read_value = values[idx];
            end
         end else if (idx >= 0) begin
            values[idx] = value;
            promote(idx);
            // capacity was lowered under the fill: shed one per update
            if (fill > cap) begin
               old = oldest_entry();
               if (old >= 0 && old != idx) begin
                  valid[old] = 1'b0;
                  fill--;
               end
            end
         end else if (fill >= cap) begin
            // full: the least recent slot takes the new key
            old = oldest_entry();
            if (old >= 0) begin
               valid[old] = 1'b0;
               insert_newest(old, k, value);
            end
         end else begin
            slot = -1;
            for (int i = 0; i < lkv_pkg::ENTRIES; i++)
               if (slot < 0 && !valid[i]) slot = i;
            if (slot >= 0) begin
               insert_newest(slot, k, value);
               fill++;
            end
         end
         pending_replies = {pending_replies, r};
      endfunction

      function void check_reply(logic hit, logic [lkv_pkg::VALUE_W-1:0] read_value);
         reply_type want;
         if (pending_replies.size() == 0) begin
            $error("reply with no word outstanding: hit %0d read_value %h", hit, read_value);
            errors++;
            return;
         end
         want = pending_replies.pop_front();
         if (hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, hit);
            errors++;
         end
         if (read_value !== want.read_value) begin
            $error("read_value: expected %h, actual %h", want.read_value, read_value);
            errors++;
         end
      endfunction
   endclass

   logic                           clock          = 1'b0;
   logic                           reset          = 1'b1;
   logic                           start          = 1'b0;
   logic                           req_kind       = lkv_pkg::KIND_GET;
   logic [lkv_pkg::KEY_PORT_W-1:0] req_key        = '0;
   logic [lkv_pkg::VALUE_W-1:0]    req_value      = '0;
   logic                           csr_wr_en      = 1'b0;
   logic [lkv_pkg::CAP_W-1:0]      csr_wr_data    = '0;
   logic                           busy;
   logic                           rsp_strobe;
   logic                           rsp_hit;
   logic [lkv_pkg::VALUE_W-1:0]    rsp_read_value;

   lru_shadow shadow = new();
   int        cycle_count = 0;

   lru_key_value_cache i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Monitor. Samples pre-edge values; the reply is checked before the word
   // taken at the same edge is noted, so a stray reply cannot consume it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) shadow.check_reply(rsp_hit, rsp_read_value);
         if (start && !busy)
            shadow.note_word(lkv_pkg::kind_type'(req_kind), req_key, req_value);
      end
   end

   // Present one word and hold it until the block takes it.
   task automatic send_word(lkv_pkg::kind_type kind, logic [lkv_pkg::KEY_PORT_W-1:0] key,
                            logic [lkv_pkg::VALUE_W-1:0] value);
      start     <= 1'b1;
      req_kind  <= kind;
      req_key   <= key;
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic pause(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop sending and wait for every outstanding reply. The first edge lets
   // the monitor note the last word taken.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (shadow.pending_replies.size() != 0) @(posedge clock);
   endtask

   // Capacity is only changed with the pipe empty and the response stage settled.
   task automatic write_capacity(logic [lkv_pkg::CAP_W-1:0] cap);
      drain();
      repeat (2) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow.capacity = cap;
   endtask

   // Random traffic over a small key pool so hits, updates and evictions are
   // all common; a few fully random keys add misses. Bursts with random gaps,
   // or back to back when gapless is set.
   task automatic run_phase(int n_words, bit gapless);
      logic [lkv_pkg::KEY_PORT_W-1:0] pool[POOL_DEPTH];
      int                             pool_n;
      int                             sent;
      int                             burst;
      logic [lkv_pkg::KEY_PORT_W-1:0] key;
      foreach (pool[i]) pool[i] = (lkv_pkg::KEY_PORT_W)'($urandom);
      pool_n = $urandom_range(2, POOL_DEPTH);
      sent   = 0;
      while (sent < n_words) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && sent < n_words) begin
            if ($urandom_range(0, 9) == 0) key = (lkv_pkg::KEY_PORT_W)'($urandom);
            else key = pool[$urandom_range(0, pool_n - 1)];
            send_word(lkv_pkg::kind_type'($urandom_range(0, 1)), key, $urandom);
            burst--;
            sent++;
         end
         if (!gapless && $urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
      end
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      logic [lkv_pkg::CAP_W-1:0] phase_caps[10];
      phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd12, 5'd2, 5'd16, 5'd8, 5'd3};
      phase_caps[9] = (lkv_pkg::CAP_W)'($urandom_range(0, 31));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty store, key/value extremes, update in place.
      send_word(lkv_pkg::KIND_GET, 16'h0000, 32'hFFFF_FFFF);   // miss on empty store
      send_word(lkv_pkg::KIND_PUT, 16'h0000, 32'h0000_0000);
      send_word(lkv_pkg::KIND_PUT, 16'hFFFF, 32'hFFFF_FFFF);
      send_word(lkv_pkg::KIND_GET, 16'hFFFF, 32'h0000_0000);
      send_word(lkv_pkg::KIND_GET, 16'h0000, 32'h5A5A_5A5A);
      send_word(lkv_pkg::KIND_PUT, 16'h0000, 32'h1234_5678);   // update present key
      send_word(lkv_pkg::KIND_GET, 16'h1234, 32'h0000_0000);   // miss
      // Fill to the reset capacity, then insert into a full store.
      for (int i = 1; i <= 14; i++)
         send_word(lkv_pkg::KIND_PUT, 16'(i), 32'hA000_0000 | i);
      send_word(lkv_pkg::KIND_PUT, 16'h8000, 32'h8000_0001);    // evicts least recent
      send_word(lkv_pkg::KIND_GET, 16'hFFFF, 32'h0000_0000);    // evicted key misses

      // Capacity lowered below the fill: gets keep all, updating puts shed one.
      write_capacity(5'd3);
      send_word(lkv_pkg::KIND_GET, 16'd7, 32'h0000_0000);
      send_word(lkv_pkg::KIND_PUT, 16'h0000, 32'hC0DE_0000);
      send_word(lkv_pkg::KIND_PUT, 16'd7, 32'hC0DE_0007);
      send_word(lkv_pkg::KIND_GET, 16'd1, 32'h0000_0000);

      for (int p = 0; p < 10; p++) begin
         write_capacity(phase_caps[p]);
         run_phase(PHASE_WORDS, (p % 4) == 1);
      end

      drain();
      repeat (4) @(posedge clock);
      if (shadow.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### filelist.f
rtl/lkv_pkg.sv
rtl/lkv_cell.sv
rtl/lru_key_value_cache.sv
test/lru_key_value_cache_test.sv
